[rtl/tcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants for the trackpad circular scroll core.
// -----------------------------------------------------------------------------
package tcs_pkg;

  localparam int unsigned RegIdxW = 1;

  typedef enum logic [RegIdxW-1:0] {
    REG_DZ_LIMIT       = 1'b0,
    REG_SCROLL_DIVISOR = 1'b1
  } tcs_reg_t;

  localparam logic [30:0] DEAD_ZONE_RESET = 31'd25;
  localparam logic [12:0] DIVISOR_RESET   = 13'd1024;

  // radix-2 steps per division: ratio quotient fits 11 bits, scroll quotient 12
  localparam logic [3:0] ANGLE_STEPS  = 4'd11;
  localparam logic [3:0] SCROLL_STEPS = 4'd12;

  localparam logic [11:0] HALF_TURN = 12'd2048;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SUM,
    S_CMP,
    S_ADIV,
    S_AWAIT,
    S_ANG,
    S_TRACK,
    S_DELTA,
    S_SDIV,
    S_SWAIT,
    S_OUT_PASS,
    S_OUT_SCROLL,
    S_OUT_ZERO
  } tcs_state_t;

  typedef enum logic [1:0] {
    OSEL_PASS,
    OSEL_SCROLL,
    OSEL_ZERO
  } tcs_osel_t;

  typedef struct packed {
    logic      load_in;
    logic      sq_x;
    logic      sq_y;
    logic      sum;
    logic      adiv_start;
    logic      ang;
    logic      track_set;
    logic      track_clr;
    logic      delta;
    logic      sdiv_start;
    logic      out_load;
    tcs_osel_t out_sel;
  } tcs_cmd_t;

  typedef struct packed {
    logic below;
    logic total_zero;
    logic tracking;
    logic div_zero;
    logic div_busy;
    logic out_free;
  } tcs_status_t;

endpackage

`default_nettype wire

[rtl/tcs_motion_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcs_motion_if
// Pointer motion channel: one relative (move_x, move_y) per transfer.
// -----------------------------------------------------------------------------
interface tcs_motion_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] move_x;
  logic signed [15:0] move_y;

  modport source(output valid, move_x, move_y, input ready);
  modport sink(input valid, move_x, move_y, output ready);
endinterface

`default_nettype wire

[rtl/tcs_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcs_result_if
// Result channel: pass-through motion or scroll event per transfer.
// -----------------------------------------------------------------------------
interface tcs_result_if;
  logic               valid;
  logic               ready;
  logic               is_scroll;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;

  modport source(output valid, is_scroll, out_x, out_y, input ready);
  modport sink(input valid, is_scroll, out_x, out_y, output ready);
endinterface

`default_nettype wire

[rtl/tcs_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcs_divider
// Restoring radix-2 divider, one quotient bit per cycle, variable step count.
// -----------------------------------------------------------------------------
module tcs_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [16:0] rem_init,
  input  wire logic [11:0] dq_init,
  input  wire logic [16:0] divisor,
  input  wire logic [3:0]  steps,
  output logic             busy,
  output logic [11:0]      quotient
);

  logic [16:0] rem;
  logic [11:0] dq;
  logic [16:0] dvsr;
  logic [3:0]  count;
  logic [18:0] diff;

  // remainder is preloaded with the dividend bits above the quotient range;
  // dq shifts the low dividend bits out and the quotient bits in
  assign diff     = {1'b0, rem, dq[11]} - {2'b00, dvsr};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= steps;
    end else if (busy) begin
      count <= count - 4'd1;
      if (count == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      dq   <= dq_init;
      dvsr <= divisor;
    end else if (busy) begin
      if (!diff[18]) begin
        rem <= diff[16:0];
        dq  <= {dq[10:0], 1'b1};
      end else begin
        rem <= {rem[15:0], dq[11]};
        dq  <= {dq[10:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tcs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcs_datapath
// Magnitude, diamond angle, angle delta and scroll amount, plus result register.
// -----------------------------------------------------------------------------
module tcs_datapath
  import tcs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tcs_cmd_t           cmd,
  output tcs_status_t             status,
  input  wire logic signed [15:0] move_x,
  input  wire logic signed [15:0] move_y,
  input  wire logic [30:0]        dz_limit,
  input  wire logic [12:0]        scroll_divisor,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic                    res_is_scroll,
  output logic signed [15:0]      res_out_x,
  output logic signed [15:0]      res_out_y
);

  logic signed [15:0] x;
  logic signed [15:0] y;
  logic [15:0]        ax;
  logic [15:0]        ay;
  logic [15:0]        mul_op;
  logic [31:0]        prod;
  logic [31:0]        mag;
  logic [16:0]        total;
  logic [11:0]        angle;
  logic [11:0]        last_angle;
  logic               tracking;
  logic [10:0]        ratio;
  logic [11:0]        angle_next;
  logic signed [12:0] diff;
  logic signed [12:0] wrapped;
  logic [12:0]        abs_wrapped;
  logic [11:0]        abs_delta;
  logic               delta_neg;
  logic [15:0]        quo_ext;
  logic [15:0]        amount;

  logic               div_start;
  logic [16:0]        div_rem_init;
  logic [11:0]        div_dq_init;
  logic [16:0]        div_divisor;
  logic [3:0]         div_steps;
  logic               div_busy;
  logic [11:0]        div_quo;

  // 16-bit unsigned magnitude; -32768 comes out as 32768
  assign ax    = x[15] ? 16'(-x) : 16'(x);
  assign ay    = y[15] ? 16'(-y) : 16'(y);
  assign total = {1'b0, ax} + {1'b0, ay};

  assign mul_op = cmd.sq_y ? ay : ax;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x <= move_x;
      y <= move_y;
    end
    if (cmd.sq_x || cmd.sq_y) begin
      prod <= mul_op * mul_op;
    end
    if (cmd.sq_y) begin
      mag <= prod;
    end else if (cmd.sum) begin
      mag <= mag + prod;
    end
  end

  // ratio division preloads ay>>1 so that only the 11 quotient bits are stepped
  assign div_start = cmd.adiv_start | cmd.sdiv_start;

  always_comb begin
    if (cmd.sdiv_start) begin
      div_rem_init = '0;
      div_dq_init  = abs_delta;
      div_divisor  = {4'b0000, scroll_divisor};
      div_steps    = SCROLL_STEPS;
    end else begin
      div_rem_init = {2'b00, ay[15:1]};
      div_dq_init  = {ay[0], 11'd0};
      div_divisor  = total;
      div_steps    = ANGLE_STEPS;
    end
  end

  tcs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .dq_init  (div_dq_init),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // zero motion has no direction: angle 0
  assign ratio = (total == 17'd0) ? 11'd0 : div_quo[10:0];

  always_comb begin
    case ({x[15], y[15]})
      2'b00:   angle_next = {1'b0, ratio};
      2'b10:   angle_next = HALF_TURN - {1'b0, ratio};
      2'b11:   angle_next = HALF_TURN + {1'b0, ratio};
      default: angle_next = 12'd0 - {1'b0, ratio};
    endcase
  end

  // angle difference wrapped into -2048..2048
  assign diff = $signed({1'b0, angle}) - $signed({1'b0, last_angle});

  always_comb begin
    if (diff > 13'sd2048) begin
      wrapped = diff - 13'sd4096;
    end else if (diff < -13'sd2048) begin
      wrapped = diff + 13'sd4096;
    end else begin
      wrapped = diff;
    end
  end

  assign abs_wrapped = wrapped[12] ? 13'(-wrapped) : 13'(wrapped);

  always_ff @(posedge clk) begin
    if (cmd.ang) begin
      angle <= angle_next;
    end
    if (cmd.delta) begin
      abs_delta <= abs_wrapped[11:0];
      delta_neg <= wrapped[12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking   <= 1'b0;
      last_angle <= '0;
    end else if (cmd.track_clr) begin
      tracking <= 1'b0;
    end else if (cmd.track_set) begin
      tracking   <= 1'b1;
      last_angle <= angle;
    end else if (cmd.delta) begin
      last_angle <= angle;
    end
  end

  assign quo_ext = {4'b0000, div_quo};
  assign amount  = delta_neg ? 16'(-quo_ext) : quo_ext;

  // result register: a finished item waits here while the next one is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OSEL_SCROLL: begin
          res_is_scroll <= 1'b1;
          res_out_x     <= '0;
          res_out_y     <= $signed(amount);
        end
        OSEL_ZERO: begin
          res_is_scroll <= 1'b1;
          res_out_x     <= '0;
          res_out_y     <= '0;
        end
        default: begin
          res_is_scroll <= 1'b0;
          res_out_x     <= x;
          res_out_y     <= y;
        end
      endcase
    end
  end

  assign status.below      = mag < {1'b0, dz_limit};
  assign status.total_zero = (total == 17'd0);
  assign status.tracking   = tracking;
  assign status.div_zero   = (scroll_divisor == 13'd0);
  assign status.div_busy   = div_busy;
  assign status.out_free   = !res_valid || res_ready;

endmodule

`default_nettype wire

[rtl/tcs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcs_ctrl
// Sequencer for one motion item: squares, dead-zone test, angle, scroll step.
// -----------------------------------------------------------------------------
module tcs_ctrl
  import tcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire tcs_status_t status,
  output tcs_cmd_t         cmd
);

  tcs_state_t state;
  tcs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SQX;
      end
      S_SQX: state_next = S_SQY;
      S_SQY: state_next = S_SUM;
      S_SUM: state_next = S_CMP;
      S_CMP: begin
        if (status.below) begin
          state_next = S_OUT_PASS;
        end else if (status.total_zero) begin
          state_next = S_ANG;
        end else begin
          state_next = S_ADIV;
        end
      end
      S_ADIV: state_next = S_AWAIT;
      S_AWAIT: begin
        if (!status.div_busy) state_next = S_ANG;
      end
      S_ANG: state_next = S_TRACK;
      S_TRACK: begin
        state_next = status.tracking ? S_DELTA : S_OUT_PASS;
      end
      S_DELTA: begin
        state_next = status.div_zero ? S_OUT_ZERO : S_SDIV;
      end
      S_SDIV: state_next = S_SWAIT;
      S_SWAIT: begin
        if (!status.div_busy) state_next = S_OUT_SCROLL;
      end
      S_OUT_PASS, S_OUT_SCROLL, S_OUT_ZERO: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.out_sel = OSEL_PASS;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_SQX: cmd.sq_x = 1'b1;
      S_SQY: cmd.sq_y = 1'b1;
      S_SUM: cmd.sum  = 1'b1;
      S_CMP: begin
        cmd.track_clr  = status.below;
        cmd.adiv_start = !status.below && !status.total_zero;
      end
      S_ADIV, S_AWAIT, S_SWAIT: begin
      end
      S_ANG: cmd.ang = 1'b1;
      S_TRACK: cmd.track_set = !status.tracking;
      S_DELTA: cmd.delta = 1'b1;
      // the delta magnitude latched in S_DELTA feeds the divider in S_SDIV
      S_SDIV: cmd.sdiv_start = 1'b1;
      S_OUT_PASS: begin
        cmd.out_load = status.out_free;
        cmd.out_sel  = OSEL_PASS;
      end
      S_OUT_SCROLL: begin
        cmd.out_load = status.out_free;
        cmd.out_sel  = OSEL_SCROLL;
      end
      S_OUT_ZERO: begin
        cmd.out_load = status.out_free;
        cmd.out_sel  = OSEL_ZERO;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/trackpad_circular_scroll_core.sv]
// Circular scroll core. Each motion transfer is turned into one result: the
// motion itself while outside circular tracking, or a scroll event whose amount
// is the wrapped change of a diamond pseudo-angle divided by scroll_divisor.
// One item is handled at a time. Most of the work on an item is done by the
// shared one-bit-per-cycle divider, which a scroll step passes through twice
// (11 steps for the angle ratio, 12 for the scroll step), and by the shared
// multiplier, which squares x and then y. The next motion can be accepted once
// the result has been registered. The finished result sits in an output
// register, so a stalled result consumer only holds up the item after it at
// its last step.
// Registers: 0x0 dz_limit, 0x4 scroll_divisor.
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// trackpad_circular_scroll_core
// Top level: register port, sequencer and datapath.
// -----------------------------------------------------------------------------
module trackpad_circular_scroll_core
  import tcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  tcs_motion_if.sink       motion,
  tcs_result_if.source     result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [30:0] dz_limit;
  logic [12:0] scroll_divisor;
  tcs_reg_t    reg_sel;
  tcs_cmd_t    cmd;
  tcs_status_t status;

  assign pready  = 1'b1;
  assign reg_sel = tcs_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dz_limit       <= DEAD_ZONE_RESET;
      scroll_divisor <= DIVISOR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_DZ_LIMIT:       dz_limit       <= pwdata[30:0];
        REG_SCROLL_DIVISOR: scroll_divisor <= pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DZ_LIMIT:       prdata = {1'b0, dz_limit};
      REG_SCROLL_DIVISOR: prdata = {19'd0, scroll_divisor};
      default:            prdata = '0;
    endcase
  end

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (motion.valid),
    .in_ready (motion.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .move_x         (motion.move_x),
    .move_y         (motion.move_y),
    .dz_limit       (dz_limit),
    .scroll_divisor (scroll_divisor),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_is_scroll  (result.is_scroll),
    .res_out_x      (result.out_x),
    .res_out_y      (result.out_y)
  );

endmodule

`default_nettype wire

[rtl/tcs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tcs_checker
// Port-level checks for the circular scroll core, bound to the top level.
// -----------------------------------------------------------------------------
module tcs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_is_scroll,
  input wire logic [15:0] out_x,
  input wire logic [15:0] out_y
);

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_is_scroll)
      && $stable(out_x) && $stable(out_y))
    else $error("stalled result changed");

  // scroll events carry no horizontal motion
  a_scroll_x_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_is_scroll |-> out_x == 16'd0)
    else $error("scroll event with nonzero out_x");

  // one item at a time: the input closes after each transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a transfer");

endmodule

bind trackpad_circular_scroll_core tcs_checker u_tcs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (motion.valid),
  .in_ready      (motion.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_is_scroll (result.is_scroll),
  .out_x         (result.out_x),
  .out_y         (result.out_y)
);

`default_nettype wire

[tb/sv/trackpad_circular_scroll_core_tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// trackpad_circular_scroll_core_tb
// Self-checking bench: drives motion transfers with random gaps, stalls the
// result side at random, programs both registers over APB between phases and
// checks every result against a diamond-angle scroll predictor.
// -----------------------------------------------------------------------------

typedef struct packed {
  logic               is_scroll;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
} scroll_event_t;

class scroll_scoreboard;
  logic [30:0]   dz_limit;
  logic [12:0]   scroll_divisor;
  bit            tracking;
  logic [11:0]   last_angle;
  scroll_event_t awaited[$];
  int            fails;

  function new();
    dz_limit       = tcs_pkg::DEAD_ZONE_RESET;
    scroll_divisor = tcs_pkg::DIVISOR_RESET;
    tracking       = 1'b0;
    last_angle     = '0;
    fails          = 0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function void set_register(tcs_pkg::tcs_reg_t which, logic [31:0] value);
    case (which)
      tcs_pkg::REG_DZ_LIMIT:       dz_limit = value[30:0];
      tcs_pkg::REG_SCROLL_DIVISOR: scroll_divisor = value[12:0];
      default: ;
    endcase
  endfunction

  // works out the result of one accepted motion and queues it
  function void take_motion(logic signed [15:0] mx, logic signed [15:0] my);
    int            ax, ay, total, ratio, raw, delta, amount;
    longint        energy;
    logic [11:0]   angle;
    scroll_event_t ev;
    ax     = (mx < 0) ? -int'(mx) : int'(mx);
    ay     = (my < 0) ? -int'(my) : int'(my);
    energy = longint'(ax) * ax + longint'(ay) * ay;
    ev     = '{is_scroll: 1'b0, out_x: mx, out_y: my};
    if (energy < longint'(dz_limit)) begin
      tracking = 1'b0;
    end else begin
      total = ax + ay;
      ratio = (total == 0) ? 0 : (ay * 1024) / total;
      case ({mx[15], my[15]})
        2'b00:   raw = ratio;
        2'b10:   raw = 2048 - ratio;
        2'b11:   raw = 2048 + ratio;
        default: raw = 4096 - ratio;
      endcase
      angle = raw[11:0];  // a full turn folds back to zero
      if (!tracking) begin
        tracking   = 1'b1;
        last_angle = angle;
      end else begin
        delta = int'(angle) - int'(last_angle);
        if (delta > 2048) delta -= 4096;
        else if (delta < -2048) delta += 4096;
        last_angle = angle;
        if (scroll_divisor == 0) begin
          amount = 0;
        end else begin
          amount = ((delta < 0) ? -delta : delta) / int'(scroll_divisor);
          if (delta < 0) amount = -amount;
        end
        ev = '{is_scroll: 1'b1, out_x: 16'sd0, out_y: amount[15:0]};
      end
    end
    awaited.push_back(ev);
  endfunction

  task report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    fails++;
  endtask

  task check_result(logic is_scroll, logic signed [15:0] ox, logic signed [15:0] oy);
    scroll_event_t want;
    if (awaited.size() == 0) begin
      report($sformatf("result with nothing pending: scroll=%0b x=%0d y=%0d",
                       is_scroll, ox, oy));
    end else begin
      want = awaited.pop_front();
      if (is_scroll !== want.is_scroll)
        report($sformatf("is_scroll %0b, want %0b", is_scroll, want.is_scroll));
      if (ox !== want.out_x)
        report($sformatf("out_x %0d, want %0d", ox, want.out_x));
      if (oy !== want.out_y)
        report($sformatf("out_y %0d, want %0d", oy, want.out_y));
    end
  endtask
endclass

module trackpad_circular_scroll_core_tb;
  import tcs_pkg::*;

  localparam logic [30:0] DeadZoneMax = 31'd2147352578;
  localparam logic [12:0] DivisorMax  = 13'd4096;
  localparam int          HoldCycles  = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit idling   = 1'b1;
  bit hold_req = 1'b0;

  scroll_scoreboard sb = new();

  tcs_motion_if motion_ch ();
  tcs_result_if result_ch ();

  trackpad_circular_scroll_core dut (
    .clk     (clk),
    .rst     (rst),
    .motion  (motion_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // first group, dead zone 100 and divisor 1: quarter turns, the full-turn fold,
  // the +/-2048 wrap edges, a wrap past 2048, and the dead-zone boundary
  int group_a_x[16] = '{0, 32767, 0, -32767, 0, 32767, -32767, 32767,
                        -32767, 7, 10, 0, -32767, -32767, -1, 32767};
  int group_a_y[16] = '{0, 0, 32767, 0, -32767, -1, -32767, 32767,
                        -32767, 7, 0, -32767, 32767, -1, -32767, 1};
  // second group, dead zone 2*32767*32767 and divisor 4096
  int group_b_x[5] = '{32767, 32767, -32767, 32767, -32767};
  int group_b_y[5] = '{32766, 32767, -32767, -32767, 32767};

  task automatic write_register(input tcs_reg_t which, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(which, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender withdraws and holds off until the block is empty, then programs it
  task automatic configure(input logic [30:0] dz, input logic [12:0] div);
    @(negedge clk);
    motion_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_register(REG_DZ_LIMIT, {1'b0, dz});
    write_register(REG_SCROLL_DIVISOR, {19'd0, div});
  endtask

  task automatic send_motion(input int mx, input int my);
    int gap;
    gap = idling ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      motion_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    motion_ch.valid  <= 1'b1;
    motion_ch.move_x <= 16'(mx);
    motion_ch.move_y <= 16'(my);
    do @(posedge clk); while (!motion_ch.ready);
    sb.take_motion(16'(mx), 16'(my));
  endtask

  task automatic random_phase(input int count, input bit program_regs,
                              input logic [30:0] dz, input logic [12:0] div,
                              input bit idle, input bit hold);
    int pick, bound, mx, my;
    if (program_regs) configure(dz, div);
    idling   = idle;
    hold_req = hold;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        mx = int'($urandom_range(0, 2)) * 32767 - 32767;
        my = int'($urandom_range(0, 2)) * 32767 - 32767;
      end else begin
        bound = (pick < 30) ? 8 : (pick < 55) ? 1024 : 32767;
        mx    = int'($urandom_range(0, 2 * bound)) - bound;
        my    = int'($urandom_range(0, 2 * bound)) - bound;
      end
      send_motion(mx, my);
    end
  endtask

  // result side: random stall per transfer, one long hold-off on request
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = idling ? $urandom_range(0, 8) : 0;
      if (hold_req) begin
        stall    = HoldCycles;
        hold_req = 1'b0;
      end
      @(negedge clk);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      sb.check_result(result_ch.is_scroll, result_ch.out_x, result_ch.out_y);
    end
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int i;
    motion_ch.valid  = 1'b0;
    motion_ch.move_x = '0;
    motion_ch.move_y = '0;
    result_ch.ready  = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values, receiver stalls long at the start
    random_phase(80, 1'b0, '0, '0, 1'b1, 1'b1);

    configure(31'd100, 13'd1);
    for (i = 0; i < 16; i++) send_motion(group_a_x[i], group_a_y[i]);
    configure(DeadZoneMax, DivisorMax);
    for (i = 0; i < 5; i++) send_motion(group_b_x[i], group_b_y[i]);

    random_phase(80, 1'b1, 31'd0, 13'd1, 1'b0, 1'b0);
    random_phase(40, 1'b1, DeadZoneMax, DivisorMax, 1'b1, 1'b0);
    random_phase(120, 1'b1, 31'($urandom_range(0, 2000)),
                 13'($urandom_range(1, 64)), 1'b1, 1'b1);
    random_phase(100, 1'b1, 31'd25, 13'($urandom_range(1, 4096)), 1'b1, 1'b0);
    random_phase(60, 1'b1, 31'($urandom_range(0, 2147352578)),
                 13'($urandom_range(1, 4096)), 1'b0, 1'b0);
    random_phase(70, 1'b1, 31'd1, 13'd2048, 1'b1, 1'b0);

    @(negedge clk);
    motion_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
